>>> design/tcg_pkg.sv
package tcg_pkg;

    localparam int ADDR_W  = 13;
    localparam int BYTE_W  = 8;
    localparam int LINE_W  = 8;
    localparam int X_W     = 11;
    localparam int MASK_W  = 11;
    localparam int SHADE_W = 8;
    localparam int CELL_WIDTH = 11;

    // Request kinds carried on req_type.
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_RENDER = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_NORMAL = 1'b0;
    localparam logic CFG_BOLD   = 1'b1;

    // One classified transaction, handed from the front end to the render engine.
    typedef struct packed {
        logic                 is_load;
        logic                 wr_ok;
        logic [ADDR_W-1:0]    wr_addr;
        logic [BYTE_W-1:0]    wr_data;
        logic [ADDR_W-1:0]    rd_base;
        logic                 oob;
        logic [LINE_W-1:0]    line_base;
        logic [X_W-1:0]       x_start;
        logic                 under;
        logic [SHADE_W-1:0]   lit;
        logic [SHADE_W-1:0]   unlit;
    } t_cmd;

endpackage

>>> design/tcg_front.sv
module tcg_front #(
    parameter int GLYPH_LINES = 10,
    parameter int GLYPH_COUNT = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_index,
    input  logic [tcg_pkg::SHADE_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_req_type,
    input  logic [tcg_pkg::ADDR_W-1:0]    i_glyph_address,
    input  logic [tcg_pkg::BYTE_W-1:0]    i_glyph_byte,
    input  logic [7:0]                    i_char_code,
    input  logic [4:0]                    i_cell_row,
    input  logic [7:0]                    i_cell_col,
    input  logic                          i_reverse_attr,
    input  logic                          i_blink_attr,
    input  logic                          i_bold_attr,
    input  logic                          i_underline_attr,
    input  logic                          i_blink_phase,
    input  logic                          i_full,
    output logic                          o_push,
    output tcg_pkg::t_cmd                 o_cmd
);

    localparam int AW = tcg_pkg::ADDR_W;
    localparam int SW = tcg_pkg::SHADE_W;
    localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_LINES * 2;
    localparam logic [AW:0] STORE_END = (AW + 1)'(STORE_DEPTH);
    localparam logic [8:0]  CODE_END  = 9'(GLYPH_COUNT);

    localparam logic [SW-1:0] NORMAL_RESET = 8'hFF;
    localparam logic [SW-1:0] BOLD_RESET   = 8'h7F;

    logic [SW-1:0] r_normal_shade;
    logic [SW-1:0] r_bold_shade;
    logic [SW-1:0] fg;
    logic          off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal_shade <= NORMAL_RESET;
            r_bold_shade   <= BOLD_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tcg_pkg::CFG_NORMAL: r_normal_shade <= i_cfg_data;
                tcg_pkg::CFG_BOLD:   r_bold_shade   <= i_cfg_data;
            endcase
        end
    end

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

    assign fg  = i_bold_attr ? r_bold_shade : r_normal_shade;
    assign off = i_blink_attr && i_blink_phase;

    always_comb begin
        o_cmd.is_load   = (i_req_type == tcg_pkg::REQ_LOAD);
        o_cmd.wr_ok     = ({1'b0, i_glyph_address} < STORE_END);
        o_cmd.wr_addr   = i_glyph_address;
        o_cmd.wr_data   = i_glyph_byte;
        o_cmd.rd_base   = {5'b0, i_char_code} * AW'(GLYPH_LINES);
        o_cmd.oob       = !({1'b0, i_char_code} < CODE_END);
        o_cmd.line_base = {3'b0, i_cell_row} * 8'(GLYPH_LINES);
        o_cmd.x_start   = {3'b0, i_cell_col} * 11'(tcg_pkg::CELL_WIDTH);
        o_cmd.under     = i_underline_attr;
        // Reverse swaps the shades; blink-off shows a reversed glyph unreversed and blanks a normal one.
        if (i_reverse_attr) begin
            o_cmd.lit   = off ? fg : '0;
            o_cmd.unlit = off ? '0 : fg;
        end else begin
            o_cmd.lit   = off ? '0 : fg;
            o_cmd.unlit = '0;
        end
    end

endmodule

>>> design/tcg_queue.sv
module tcg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tcg_pkg::t_cmd  i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output tcg_pkg::t_cmd  o_cmd,
    input  logic           i_pop
);

    tcg_pkg::t_cmd r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

>>> design/tcg_back.sv
module tcg_back #(
    parameter int GLYPH_LINES = 10,
    parameter int GLYPH_COUNT = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  tcg_pkg::t_cmd                 i_cmd,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tcg_pkg::LINE_W-1:0]    o_line_y,
    output logic [tcg_pkg::X_W-1:0]       o_x_start,
    output logic [tcg_pkg::MASK_W-1:0]    o_lit_mask,
    output logic [tcg_pkg::SHADE_W-1:0]   o_lit_shade,
    output logic [tcg_pkg::SHADE_W-1:0]   o_unlit_shade,
    output logic                          o_last_line
);

    localparam int BANK_DEPTH = GLYPH_COUNT * GLYPH_LINES;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int Y_W        = $clog2(GLYPH_LINES);
    localparam logic [Y_W-1:0] LAST_Y = Y_W'(GLYPH_LINES - 1);
    localparam int LW = tcg_pkg::LINE_W;
    localparam int XW = tcg_pkg::X_W;
    localparam int SW = tcg_pkg::SHADE_W;

    typedef enum logic [1:0] {
        BK_IDLE   = 2'b01,
        BK_RENDER = 2'b10
    } t_back_state;

    // Glyph store split into even (pixels 0..7) and odd (pixels 8..10) bytes.
    logic [7:0]         r_even [BANK_DEPTH];
    logic [2:0]         r_odd  [BANK_DEPTH];
    logic [7:0]         r_q0;
    logic [2:0]         r_q1;

    t_back_state        r_state, n_state;
    logic [Y_W-1:0]     r_y, n_y;
    logic [BANK_AW-1:0] r_idx, n_idx;
    logic [LW-1:0]      r_line_base;
    logic [XW-1:0]      r_x_start;
    logic               r_under, r_oob;
    logic [SW-1:0]      r_lit, r_unlit;

    logic               r_s1_valid;
    logic [LW-1:0]      r_s1_line_y;
    logic               r_s1_last, r_s1_force, r_s1_oob;
    logic [XW-1:0]      r_s1_x_start;
    logic [SW-1:0]      r_s1_lit, r_s1_unlit;

    logic               r_out_valid;
    logic [LW-1:0]      r_out_line_y;
    logic [XW-1:0]      r_out_x_start;
    logic [tcg_pkg::MASK_W-1:0] r_out_mask;
    logic [SW-1:0]      r_out_lit, r_out_unlit;
    logic               r_out_last;

    logic               out_free, s1_adv, issue, last_issue, pop, wr_en, wr_bank;
    logic [BANK_AW-1:0] wr_index;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = !r_s1_valid || out_free;
    assign issue      = (r_state == BK_RENDER) && s1_adv;
    assign last_issue = issue && (r_y == LAST_Y);
    assign pop        = i_q_valid && ((r_state == BK_IDLE) || last_issue);
    assign o_pop      = pop;
    assign wr_en      = pop && i_cmd.is_load && i_cmd.wr_ok;
    assign wr_bank    = i_cmd.wr_addr[0];
    assign wr_index   = i_cmd.wr_addr[BANK_AW:1];

    always_ff @(posedge i_clk) begin
        if (wr_en && !wr_bank) begin
            r_even[wr_index] <= i_cmd.wr_data;
        end
        if (issue) begin
            r_q0 <= r_even[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && wr_bank) begin
            r_odd[wr_index] <= i_cmd.wr_data[2:0];
        end
        if (issue) begin
            r_q1 <= r_odd[r_idx];
        end
    end

    always_comb begin
        n_state = r_state;
        n_y     = r_y;
        n_idx   = r_idx;
        unique case (r_state)
            BK_IDLE: begin
            end
            BK_RENDER: begin
                if (issue) begin
                    n_y   = r_y + Y_W'(1);
                    n_idx = r_idx + BANK_AW'(1);
                    if (r_y == LAST_Y) begin
                        n_state = BK_IDLE;
                        n_y     = '0;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
                n_y     = '0;
            end
        endcase
        if (pop && !i_cmd.is_load) begin
            n_state = BK_RENDER;
            n_y     = '0;
            n_idx   = i_cmd.rd_base[BANK_AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_y     <= '0;
        end else begin
            r_state <= n_state;
            r_y     <= n_y;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (pop && !i_cmd.is_load) begin
            r_line_base <= i_cmd.line_base;
            r_x_start   <= i_cmd.x_start;
            r_under     <= i_cmd.under;
            r_oob       <= i_cmd.oob;
            r_lit       <= i_cmd.lit;
            r_unlit     <= i_cmd.unlit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s1_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_line_y  <= r_line_base + LW'(r_y);
            r_s1_last    <= (r_y == LAST_Y);
            r_s1_force   <= r_under && (r_y == LAST_Y);
            r_s1_oob     <= r_oob;
            r_s1_x_start <= r_x_start;
            r_s1_lit     <= r_lit;
            r_s1_unlit   <= r_unlit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_line_y  <= r_s1_line_y;
            r_out_x_start <= r_s1_x_start;
            r_out_lit     <= r_s1_lit;
            r_out_unlit   <= r_s1_unlit;
            r_out_last    <= r_s1_last;
            if (r_s1_force) begin
                r_out_mask <= '1;
            end else if (r_s1_oob) begin
                r_out_mask <= '0;
            end else begin
                r_out_mask <= {r_q0, r_q1};
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_line_y      = r_out_line_y;
    assign o_x_start     = r_out_x_start;
    assign o_lit_mask    = r_out_mask;
    assign o_lit_shade   = r_out_lit;
    assign o_unlit_shade = r_out_unlit;
    assign o_last_line   = r_out_last;

`ifndef ASSERT_OFF
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> r_s1_valid)
        else $error("scanline dropped from read stage while output stalled");

    a_idle_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_IDLE) |-> (r_y == '0))
        else $error("scanline counter not cleared when idle");

    a_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> ((r_state == BK_IDLE) || (r_y == LAST_Y)))
        else $error("glyph write during a render");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_line && !i_out_stall) |=> !(o_out_valid && o_last_line))
        else $error("two final scanlines back to back");
`endif

endmodule

>>> design/text_char_generator_core.sv
// Text-mode character generator. Load transactions (req_type 0) write one glyph
// byte and produce nothing; render transactions (req_type 1) produce GLYPH_LINES
// scanline transactions, top to bottom, each with the screen line, the cell's
// start x, an 11-bit lit mask (MSB = leftmost pixel) and the lit/unlit shades.
// A front end classifies each transaction and computes position and shades, a
// two-entry queue decouples it from the render engine, and the engine reads the
// glyph store (even and odd byte banks, one read each per cycle) once per
// scanline. A render holds the engine until its last scanline is read; a load
// is done in the cycle it is taken. The next transaction is taken from the queue
// in the cycle of the last scanline read, so renders sustain one scanline per
// cycle while the output is not stalled. Each scanline passes through a read
// stage, where both banks are read, and then the output register. Glyph bytes
// must be written before they are rendered. The config port is always ready;
// write it only while the block is idle.
module text_char_generator_core #(
    parameter int GLYPH_LINES = 10,
    parameter int GLYPH_COUNT = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [tcg_pkg::SHADE_W-1:0]   i_cfg_data,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_req_type,
    input  logic [tcg_pkg::ADDR_W-1:0]    i_glyph_address,
    input  logic [tcg_pkg::BYTE_W-1:0]    i_glyph_byte,
    input  logic [7:0]                    i_char_code,
    input  logic [4:0]                    i_cell_row,
    input  logic [7:0]                    i_cell_col,
    input  logic                          i_reverse_attr,
    input  logic                          i_blink_attr,
    input  logic                          i_bold_attr,
    input  logic                          i_underline_attr,
    input  logic                          i_blink_phase,
    // scanline channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tcg_pkg::LINE_W-1:0]    o_line_y,
    output logic [tcg_pkg::X_W-1:0]       o_x_start,
    output logic [tcg_pkg::MASK_W-1:0]    o_lit_mask,
    output logic [tcg_pkg::SHADE_W-1:0]   o_lit_shade,
    output logic [tcg_pkg::SHADE_W-1:0]   o_unlit_shade,
    output logic                          o_last_line
);

    tcg_pkg::t_cmd push_cmd;
    tcg_pkg::t_cmd head_cmd;
    logic          push, q_full, q_valid, pop;

    // Shade registers accept every write immediately.
    assign o_cfg_ready = 1'b1;

    // Classify the transaction and precompute everything the engine needs.
    tcg_front #(
        .GLYPH_LINES (GLYPH_LINES),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_glyph_address  (i_glyph_address),
        .i_glyph_byte     (i_glyph_byte),
        .i_char_code      (i_char_code),
        .i_cell_row       (i_cell_row),
        .i_cell_col       (i_cell_col),
        .i_reverse_attr   (i_reverse_attr),
        .i_blink_attr     (i_blink_attr),
        .i_bold_attr      (i_bold_attr),
        .i_underline_attr (i_underline_attr),
        .i_blink_phase    (i_blink_phase),
        .i_full           (q_full),
        .o_push           (push),
        .o_cmd            (push_cmd)
    );

    // Hold classified transactions in order; loads and renders share it so a
    // later load never overtakes an earlier render.
    tcg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    // Execute loads and step through the scanlines of each render.
    tcg_back #(
        .GLYPH_LINES (GLYPH_LINES),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_line_y      (o_line_y),
        .o_x_start     (o_x_start),
        .o_lit_mask    (o_lit_mask),
        .o_lit_shade   (o_lit_shade),
        .o_unlit_shade (o_unlit_shade),
        .o_last_line   (o_last_line)
    );

endmodule
